// ----- rtl/core/ukt_pkg.sv -----
// Shared definitions for the unique key table block.
// Opcodes, fixed field widths and the sequencer state type.
// No dependencies.
package ukt_pkg;

   // Fixed field widths of the request and response transactions
   localparam int unsigned OPCODE_W  = 2;
   localparam int unsigned KEY_IN_W  = 32;
   localparam int unsigned PAYLOAD_W = 32;
   localparam int unsigned INDEX_W   = 4;
   localparam int unsigned COUNT_W   = 5;
   localparam int unsigned CAP_W     = 5;

   // Reset value of the capacity register
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Opcodes; code three is unused and always rejected
   localparam logic [OPCODE_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd2;

   // Response status codes
   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   // Sequencer states, one-hot
   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_SCAN_RD  = 6'b000010,
      ST_SCAN_CMP = 6'b000100,
      ST_SHIFT_RD = 6'b001000,
      ST_SHIFT_WR = 6'b010000,
      ST_DONE     = 6'b100000
   } state_type;

endpackage

// ----- rtl/core/unique_key_table_with_compaction.sv -----
// Top level of the unique key table with shift compaction.
// Holds the sequencer, the shared key comparator and the response register.
// Depends on ukt_pkg and ukt_table.
//
// Usage:
//   Request channel req_*: tuser carries the opcode (add, lookup, remove),
//   tdata the key and payload. Response channel rsp_*: one transaction per
//   request with status, matched index and the entry count afterwards.
//   csr_we/csr_wdata set the capacity (entries allowed in use, capped at DEPTH).
// Sequencing:
//   One request at a time; req_tready is high only while the sequencer idles.
//   The stored keys are compared one at a time by a single comparator, each
//   entry taking a memory read state, then a compare state. An add or a miss
//   scans every stored entry; a hit stops the scan at its position. A remove
//   then moves each later entry down (read state, then write state) and clears
//   the vacated top slot. Zero keys and the unused opcode skip the scan and are rejected.
// Reset:
//   Synchronous reset empties the table (count goes to zero, no memory sweep
//   is needed) and sets capacity to 16.
// Stall:
//   A response waits in its output register while rsp_tready is low; the next
//   request may be accepted meanwhile and its result holds until the slot frees.
module unique_key_table_with_compaction #(
   parameter int unsigned DEPTH     = 16,
   parameter int unsigned KEY_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   // request: tdata = {payload[63:32], key[31:0]}
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [63:0]                  req_tdata,
   // request: tuser = {opcode[1:0]}
   input  logic [ukt_pkg::OPCODE_W-1:0] req_tuser,
   // response: tdata = {zero[15:10], count[9:5], index[4:1], status[0]}
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [15:0]                  rsp_tdata,
   // capacity register
   input  logic                         csr_we,
   input  logic [ukt_pkg::CAP_W-1:0]    csr_wdata
);
   import ukt_pkg::*;

   localparam int unsigned AW    = $clog2(DEPTH);
   localparam int unsigned CW    = $clog2(DEPTH + 1);
   localparam int unsigned KW_IN = (KEY_WIDTH < KEY_IN_W) ? KEY_WIDTH : KEY_IN_W;
   localparam int unsigned CMPW  = (CW > CAP_W) ? CW : CAP_W;

   state_type               state_ff, state_in;
   logic [OPCODE_W-1:0]     op_ff, op_in;
   logic [KEY_WIDTH-1:0]    key_ff, key_in;
   logic [PAYLOAD_W-1:0]    pay_ff, pay_in;
   logic [CW-1:0]           idx_ff, idx_in;
   logic [CW-1:0]           pos_ff, pos_in;
   logic                    status_ff, status_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CAP_W-1:0]        capacity_ff, capacity_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0]      rsp_index_ff, rsp_index_in;
   logic [COUNT_W-1:0]      rsp_count_ff, rsp_count_in;

   logic [KEY_WIDTH-1:0]    req_key;
   logic [CW:0]             idx_next;
   logic                    has_room;
   logic                    key_hit;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [KEY_WIDTH-1:0]    wr_key;
   logic [PAYLOAD_W-1:0]    wr_payload;
   logic [AW-1:0]           rd_addr;
   logic [KEY_WIDTH-1:0]    rd_key;
   logic [PAYLOAD_W-1:0]    rd_payload;

   ukt_table #(
      .DEPTH     (DEPTH),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_table (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_key     (wr_key),
      .wr_payload (wr_payload),
      .rd_addr    (rd_addr),
      .rd_key     (rd_key),
      .rd_payload (rd_payload)
   );

   // key masked to its compared width
   always_comb begin
      req_key = '0;
      req_key[KW_IN-1:0] = req_tdata[KW_IN-1:0];
   end

   // shared index incrementer and key comparator
   assign idx_next = {1'b0, idx_ff} + {{CW{1'b0}}, 1'b1};
   assign key_hit  = (rd_key == key_ff);
   assign has_room = (CMPW'(count_ff) < CMPW'(capacity_ff)) && (count_ff < CW'(DEPTH));
   assign rd_addr  = (state_ff == ST_SHIFT_RD) ? idx_next[AW-1:0] : idx_ff[AW-1:0];

   assign req_tready = (state_ff == ST_IDLE);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      pay_in        = pay_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      status_in     = status_ff;
      count_in      = count_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff[AW-1:0];
      wr_key        = rd_key;
      wr_payload    = rd_payload;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_count_in  = rsp_count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in     = req_tuser;
               key_in    = req_key;
               pay_in    = req_tdata[KEY_IN_W +: PAYLOAD_W];
               idx_in    = '0;
               pos_in    = '0;
               status_in = STATUS_REJECT;
               if (req_key == '0 || !(req_tuser == OP_ADD || req_tuser == OP_LOOKUP ||
                                      req_tuser == OP_REMOVE)) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SCAN_RD;
               end
            end
         end
         ST_SCAN_RD: begin
            if (idx_ff >= count_ff) begin
               // key absent: only an add with room succeeds
               if (op_ff == OP_ADD && has_room) begin
                  wr_en      = 1'b1;
                  wr_addr    = count_ff[AW-1:0];
                  wr_key     = key_ff;
                  wr_payload = pay_ff;
                  count_in   = CW'(count_ff + 1'b1);
                  status_in  = STATUS_OK;
               end
               state_in = ST_DONE;
            end else begin
               state_in = ST_SCAN_CMP;
            end
         end
         ST_SCAN_CMP: begin
            if (key_hit) begin
               if (op_ff == OP_ADD) begin
                  state_in = ST_DONE;
               end else begin
                  status_in = STATUS_OK;
                  pos_in    = idx_ff;
                  state_in  = (op_ff == OP_REMOVE) ? ST_SHIFT_RD : ST_DONE;
               end
            end else begin
               idx_in   = idx_next[CW-1:0];
               state_in = ST_SCAN_RD;
            end
         end
         ST_SHIFT_RD: begin
            if (idx_next < {1'b0, count_ff}) begin
               state_in = ST_SHIFT_WR;
            end else begin
               // clear the vacated top slot
               wr_en      = 1'b1;
               wr_key     = '0;
               wr_payload = '0;
               count_in   = CW'(count_ff - 1'b1);
               state_in   = ST_DONE;
            end
         end
         ST_SHIFT_WR: begin
            wr_en    = 1'b1;
            idx_in   = idx_next[CW-1:0];
            state_in = ST_SHIFT_RD;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_index_in  = INDEX_W'(pos_ff);
               rsp_count_in  = COUNT_W'(count_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // capacity register
   assign capacity_in = csr_we ? csr_wdata : capacity_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         capacity_ff  <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      pay_ff        <= pay_in;
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_count_ff, rsp_index_ff, rsp_status_ff};

   // checks on the sequencer
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above table depth");

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == ST_IDLE)
      else $error("request taken while sequencer busy");

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN_CMP |-> idx_ff < count_ff)
      else $error("compare beyond stored entries");

   a_shift_remove: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT_RD || state_ff == ST_SHIFT_WR) |-> op_ff == OP_REMOVE)
      else $error("shift outside a remove");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_SCAN_RD && state_ff != ST_SHIFT_RD) |=> $stable(count_ff))
      else $error("count changed outside an update step");

endmodule

// ----- rtl/core/ukt_table.sv -----
// Entry storage for the unique key table: key and payload memories.
// One write port, one read port with registered read data.
// Depends on ukt_pkg.
module ukt_table #(
   parameter int unsigned DEPTH     = 16,
   parameter int unsigned KEY_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [KEY_WIDTH-1:0]          wr_key,
   input  logic [ukt_pkg::PAYLOAD_W-1:0] wr_payload,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [KEY_WIDTH-1:0]          rd_key,
   output logic [ukt_pkg::PAYLOAD_W-1:0] rd_payload
);
   import ukt_pkg::*;

   logic [KEY_WIDTH-1:0] key_mem [DEPTH];
   logic [PAYLOAD_W-1:0] pay_mem [DEPTH];
   logic [KEY_WIDTH-1:0] rd_key_ff;
   logic [PAYLOAD_W-1:0] rd_payload_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_key;
         pay_mem[wr_addr] <= wr_payload;
      end
   end

   // registered read port, reads every cycle
   always_ff @(posedge clock) begin
      rd_key_ff     <= key_mem[rd_addr];
      rd_payload_ff <= pay_mem[rd_addr];
   end

   assign rd_key     = rd_key_ff;
   assign rd_payload = rd_payload_ff;

endmodule

// ----- test/tb_unique_key_table_with_compaction.sv -----
// Self-checking testbench for unique_key_table_with_compaction.
// Tracks its own copy of the key table, applies directed and random add/lookup/remove
// traffic under several capacity values, and checks every response. Depends on ukt_pkg.
module tb_unique_key_table_with_compaction;
   import ukt_pkg::*;

   localparam int unsigned      TBL_DEPTH     = 16;
   localparam logic [OPCODE_W-1:0] OP_UNUSED  = 2'd3;
   localparam int unsigned      ITEMS_PER_PHASE = 250;
   localparam int unsigned      N_PHASES      = 8;
   localparam int unsigned      STALL_LIMIT   = 5000;
   localparam int unsigned      HOLD_CYCLES   = 400;
   localparam int unsigned      N_POOL        = 24;
   // capacity per random phase: saturating, full, below the fill level, zero, past DEPTH
   localparam logic [CAP_W-1:0] PHASE_CAPS [N_PHASES] = '{
      5'd31, 5'd16, 5'd3, 5'd0, 5'd16, 5'd5, 5'd1, 5'd17
   };

   // response fields, lowest bit last in the declaration
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [INDEX_W-1:0] index;
      logic               status;
   } ukt_result_t;

   // Table tracker: mirrors the block's key table and holds pending responses
   class key_table_checker;
      logic [KEY_IN_W-1:0]  stored_keys [TBL_DEPTH];
      logic [PAYLOAD_W-1:0] stored_payloads [TBL_DEPTH];
      int unsigned          n_stored;
      logic [CAP_W-1:0]     capacity;
      ukt_result_t          expected_responses [$];
      int unsigned          n_errors;

      function new();
         foreach (stored_keys[i]) begin
            stored_keys[i] = '0;
            stored_payloads[i] = '0;
         end
         n_stored = 0;
         capacity = CAP_RESET;
         n_errors = 0;
      endfunction

      function void set_capacity(logic [CAP_W-1:0] cap);
         capacity = cap;
      endfunction

      function bit drained();
         return expected_responses.size() == 0;
      endfunction

      // apply one accepted request to the table and queue its response
      function void note_request(logic [OPCODE_W-1:0] op, logic [KEY_IN_W-1:0] key,
                                 logic [PAYLOAD_W-1:0] payload);
         ukt_result_t r;
         bit          hit;
         int unsigned pos;
         int unsigned limit;
         int unsigned i;
         r.status = STATUS_REJECT;
         r.index  = '0;
         hit = 1'b0;
         pos = 0;
         limit = (capacity > TBL_DEPTH) ? TBL_DEPTH : capacity;
         for (i = 0; i < n_stored; i++)
            if (!hit && stored_keys[i] == key) begin
               hit = 1'b1;
               pos = i;
            end
         if (key != '0) begin
            case (op)
               OP_ADD: begin
                  if (n_stored < limit && !hit) begin
                     stored_keys[n_stored] = key;
                     stored_payloads[n_stored] = payload;
                     n_stored++;
                     r.status = STATUS_OK;
                  end
               end
               OP_LOOKUP: begin
                  if (hit) begin
                     r.index  = pos[INDEX_W-1:0];
                     r.status = STATUS_OK;
                  end
               end
               OP_REMOVE: begin
                  if (hit) begin
                     for (i = pos; i + 1 < n_stored; i++) begin
                        stored_keys[i] = stored_keys[i+1];
                        stored_payloads[i] = stored_payloads[i+1];
                     end
                     n_stored--;
                     stored_keys[n_stored] = '0;
                     stored_payloads[n_stored] = '0;
                     r.index  = pos[INDEX_W-1:0];
                     r.status = STATUS_OK;
                  end
               end
               default: ;
            endcase
         end
         r.count = n_stored[COUNT_W-1:0];
         expected_responses.push_back(r);
      endfunction

      // compare one accepted response against the oldest expectation
      function void check_response(logic [15:0] data);
         ukt_result_t got;
         ukt_result_t want;
         bit          bad;
         got = data[9:0];
         if (expected_responses.size() == 0) begin
            n_errors++;
            if (n_errors <= 10)
               $display("unexpected response: status=%0d index=%0d count=%0d",
                        got.status, got.index, got.count);
            return;
         end
         want = expected_responses.pop_front();
         bad = 1'b0;
         if (got.status !== want.status) bad = 1'b1;
         if (got.index !== want.index) bad = 1'b1;
         if (got.count !== want.count) bad = 1'b1;
         if (data[15:10] !== '0) bad = 1'b1;
         if (bad) begin
            n_errors++;
            if (n_errors <= 10)
               $display("response mismatch: expected status=%0d index=%0d count=%0d pad=0, %s",
                        want.status, want.index, want.count,
                        $sformatf("got status=%0d index=%0d count=%0d pad=%0h",
                                  got.status, got.index, got.count, data[15:10]));
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [63:0]         req_tdata;   // key[31:0], payload[63:32]
   logic [OPCODE_W-1:0] req_tuser;   // opcode[1:0]
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [15:0]         rsp_tdata;   // status[0], index[4:1], count[9:5], zero[15:10]
   logic                csr_we;
   logic [CAP_W-1:0]    csr_wdata;

   key_table_checker    table_chk = new();
   logic [KEY_IN_W-1:0] key_pool [N_POOL];
   bit                  no_idle;
   bit                  hold_request;
   int unsigned         quiet_cycles;

   unique_key_table_with_compaction i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // present one request and hold it until the block takes it
   task automatic send_req(logic [OPCODE_W-1:0] op, logic [KEY_IN_W-1:0] key,
                           logic [PAYLOAD_W-1:0] payload);
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < 30) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = {payload, key};
      do @(posedge clock); while (!req_tready);
      table_chk.note_request(op, key, payload);
   endtask

   // stop offering requests until every pending response has arrived
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (!table_chk.drained()) @(negedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] cap);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_wdata = cap;
      @(negedge clock);
      csr_we    = 1'b0;
      table_chk.set_capacity(cap);
   endtask

   function automatic logic [OPCODE_W-1:0] pick_opcode();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 45) return OP_ADD;
      if (r < 70) return OP_LOOKUP;
      if (r < 95) return OP_REMOVE;
      return OP_UNUSED;
   endfunction

   // mostly keys from a small pool so that hits and duplicates are common
   function automatic logic [KEY_IN_W-1:0] pick_key();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 3) return '0;
      if (r < 10) return $urandom();
      return key_pool[$urandom_range(N_POOL-1)];
   endfunction

   // response ready: random idling, a no-idle stretch, and one long hold-off
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end
         rsp_tready = no_idle || ($urandom_range(99) >= 30);
      end
   end

   // response monitor and stall watchdog
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            table_chk.check_response(rsp_tdata);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      int unsigned p;
      int unsigned n;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = OP_ADD;
      csr_we       = 1'b0;
      csr_wdata    = '0;
      no_idle      = 1'b0;
      hold_request = 1'b0;
      key_pool[0] = 32'h0000_0001;
      key_pool[1] = 32'hFFFF_FFFF;
      key_pool[2] = 32'h8000_0000;
      for (n = 3; n < N_POOL; n++)
         key_pool[n] = $urandom() | 32'h1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: zero keys, unused opcode, duplicates, hits, misses, compaction
      send_req(OP_ADD, 32'h0, 32'hFFFF_FFFF);
      send_req(OP_LOOKUP, 32'h0, 32'h0);
      send_req(OP_REMOVE, 32'h0, 32'h0);
      send_req(OP_UNUSED, 32'h5, 32'h1234_5678);
      send_req(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_req(OP_ADD, 32'h1, 32'h0);
      send_req(OP_ADD, 32'h1, 32'hAAAA_AAAA);
      send_req(OP_ADD, 32'h8000_0000, 32'h5555_5555);
      send_req(OP_LOOKUP, 32'h8000_0000, 32'h0);
      send_req(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0);
      send_req(OP_LOOKUP, 32'h7, 32'h0);
      send_req(OP_REMOVE, 32'h1, 32'h0);
      send_req(OP_LOOKUP, 32'h8000_0000, 32'h0);
      send_req(OP_REMOVE, 32'h1, 32'h0);
      send_req(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // full table at a small capacity
      wait_drained();
      write_capacity(5'd2);
      send_req(OP_ADD, 32'h9, 32'h0);
      send_req(OP_REMOVE, 32'hFFFF_FFFF, 32'h0);
      send_req(OP_ADD, 32'h9, 32'h0F0F_0F0F);
      send_req(OP_ADD, 32'hAAAA_AAAA, 32'h0);
      // capacity zero rejects every add, searches still work
      wait_drained();
      write_capacity(5'd0);
      send_req(OP_ADD, 32'h3, 32'h0);
      send_req(OP_REMOVE, 32'h9, 32'h0);
      send_req(OP_REMOVE, 32'h8000_0000, 32'h0);
      send_req(OP_LOOKUP, 32'h9, 32'h0);

      // random phases, each under its own capacity
      for (p = 0; p < N_PHASES; p++) begin
         wait_drained();
         write_capacity(PHASE_CAPS[p]);
         no_idle = (p == 1);
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (p == 4 && n == 40) hold_request = 1'b1;
            if (p == 5 && n == 120) wait_drained();
            send_req(pick_opcode(), pick_key(), $urandom());
         end
      end

      wait_drained();
      repeat (20) @(negedge clock);
      if (table_chk.n_errors == 0 && table_chk.drained())
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule
